// ===== src/vrpp_pkg.sv =====
// shared widths, register map, configuration bundle and helpers of the vertex projection core
`timescale 1ns / 1ps
`default_nettype none
package vrpp_pkg;

  localparam int COORD_W   = 24;
  localparam int COEF_W    = 18;
  localparam int PIX_W     = 16;
  localparam int ROW_W     = 3 * COEF_W;
  localparam int FOCAL_W   = 24;
  localparam int DEPTH_W   = 23;
  localparam int SCR_W     = 14;
  localparam int FRAC_W    = 16;
  localparam int FOCAL_FRAC = 8;
  localparam int HALF_SHIFT = FOCAL_FRAC - 1;

  localparam int PROD_W    = COEF_W + COORD_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int ROT_W     = SUM_W - FRAC_W;
  localparam int DEN_W     = ROT_W + 1;
  localparam int SCALED_W  = ROT_W + FOCAL_W + 1;
  localparam int CENTER_W  = SCR_W + 1 + DEN_W;
  localparam int NUM_W     = SCALED_W + 1;
  localparam int DIVU_W    = DEN_W - 1 + FOCAL_FRAC;
  localparam int QUO_W     = PIX_W + 1;
  localparam int CMP_W     = NUM_W + 1;

  localparam int DATA_W    = 64;
  localparam int ADDR_W    = 6;
  localparam int IDX_LSB   = 3;

  typedef enum logic [2:0] {
    REG_ROW_X  = 3'd0,
    REG_ROW_Y  = 3'd1,
    REG_ROW_Z  = 3'd2,
    REG_FOCAL  = 3'd3,
    REG_DEPTH  = 3'd4,
    REG_SCR_W  = 3'd5,
    REG_SCR_H  = 3'd6
  } reg_idx_e;

  localparam logic [ROW_W-1:0]   ROW_X_RST = ROW_W'(1) << FRAC_W;
  localparam logic [ROW_W-1:0]   ROW_Y_RST = ROW_W'(1) << (COEF_W + FRAC_W);
  localparam logic [ROW_W-1:0]   ROW_Z_RST = ROW_W'(1) << (2 * COEF_W + FRAC_W);
  localparam logic [FOCAL_W-1:0] FOCAL_RST = FOCAL_W'(102400);
  localparam logic [DEPTH_W-1:0] DEPTH_RST = DEPTH_W'(327680);
  localparam logic [SCR_W-1:0]   SCR_W_RST = SCR_W'(640);
  localparam logic [SCR_W-1:0]   SCR_H_RST = SCR_W'(480);

  typedef struct packed {
    logic [ROW_W-1:0]   row_x;
    logic [ROW_W-1:0]   row_y;
    logic [ROW_W-1:0]   row_z;
    logic [FOCAL_W-1:0] focal;
    logic [DEPTH_W-1:0] depth;
    logic [SCR_W-1:0]   scr_w;
    logic [SCR_W-1:0]   scr_h;
  } cfg_t;

  function automatic logic signed [COEF_W-1:0] coef_f(input logic [ROW_W-1:0] row,
                                                      input int unsigned k);
    return signed'(row[k*COEF_W +: COEF_W]);
  endfunction

endpackage
`default_nettype wire

// ===== src/vrpp_cfg.sv =====
// apb register file holding the matrix rows and projection settings
`timescale 1ns / 1ps
`default_nettype none
module vrpp_cfg
  import vrpp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:IDX_LSB];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        REG_ROW_X: cfg_d.row_x = pwdata[ROW_W-1:0];
        REG_ROW_Y: cfg_d.row_y = pwdata[ROW_W-1:0];
        REG_ROW_Z: cfg_d.row_z = pwdata[ROW_W-1:0];
        REG_FOCAL: cfg_d.focal = pwdata[FOCAL_W-1:0];
        REG_DEPTH: cfg_d.depth = pwdata[DEPTH_W-1:0];
        REG_SCR_W: cfg_d.scr_w = pwdata[SCR_W-1:0];
        REG_SCR_H: cfg_d.scr_h = pwdata[SCR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROW_X: prdata = DATA_W'(cfg_q.row_x);
      REG_ROW_Y: prdata = DATA_W'(cfg_q.row_y);
      REG_ROW_Z: prdata = DATA_W'(cfg_q.row_z);
      REG_FOCAL: prdata = DATA_W'(cfg_q.focal);
      REG_DEPTH: prdata = DATA_W'(cfg_q.depth);
      REG_SCR_W: prdata = DATA_W'(cfg_q.scr_w);
      REG_SCR_H: prdata = DATA_W'(cfg_q.scr_h);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_x <= ROW_X_RST;
      cfg_q.row_y <= ROW_Y_RST;
      cfg_q.row_z <= ROW_Z_RST;
      cfg_q.focal <= FOCAL_RST;
      cfg_q.depth <= DEPTH_RST;
      cfg_q.scr_w <= SCR_W_RST;
      cfg_q.scr_h <= SCR_H_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/vrpp_rotate.sv =====
// two-stage 3x3 matrix times vertex, floored to q.16
`timescale 1ns / 1ps
`default_nettype none
module vrpp_rotate
  import vrpp_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      valid_i,
  input  wire logic signed [COORD_W-1:0] vx_i,
  input  wire logic signed [COORD_W-1:0] vy_i,
  input  wire logic signed [COORD_W-1:0] vz_i,
  input  wire cfg_t                      cfg_i,
  output logic                           valid_o,
  output logic signed [ROT_W-1:0]        rx_o,
  output logic signed [ROT_W-1:0]        ry_o,
  output logic signed [ROT_W-1:0]        rz_o
);

  logic [ROW_W-1:0]          rows [3];
  logic signed [COORD_W-1:0] vert [3];
  logic signed [PROD_W-1:0]  prod_d [3][3];
  logic signed [PROD_W-1:0]  prod_q [3][3];
  logic signed [SUM_W-1:0]   sum [3];
  logic signed [ROT_W-1:0]   rot_d [3];
  logic signed [ROT_W-1:0]   rot_q [3];
  logic [1:0]                valid_q;

  assign rows[0] = cfg_i.row_x;
  assign rows[1] = cfg_i.row_y;
  assign rows[2] = cfg_i.row_z;
  assign vert[0] = vx_i;
  assign vert[1] = vy_i;
  assign vert[2] = vz_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = coef_f(rows[r], c) * vert[c];
      end
      sum[r] = SUM_W'(prod_q[r][0]) + SUM_W'(prod_q[r][1]) + SUM_W'(prod_q[r][2]);
      rot_d[r] = signed'(sum[r][SUM_W-1:FRAC_W]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      rot_q  <= rot_d;
    end
  end

  assign valid_o = valid_q[1];
  assign rx_o    = rot_q[0];
  assign ry_o    = rot_q[1];
  assign rz_o    = rot_q[2];

endmodule
`default_nettype wire

// ===== src/vrpp_project.sv =====
// three-stage depth offset, focal and centering products, numerators and divisor
`timescale 1ns / 1ps
`default_nettype none
module vrpp_project
  import vrpp_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire logic signed [ROT_W-1:0] rx_i,
  input  wire logic signed [ROT_W-1:0] ry_i,
  input  wire logic signed [ROT_W-1:0] rz_i,
  input  wire cfg_t                    cfg_i,
  output logic                         valid_o,
  output logic signed [NUM_W-1:0]      num_x_o,
  output logic signed [NUM_W-1:0]      num_y_o,
  output logic [DIVU_W-1:0]            div_o,
  output logic                         behind_o
);

  logic [2:0]                  valid_q;
  logic signed [DEN_W-1:0]     den_q, den2_q;
  logic signed [ROT_W-1:0]     rx_q, ry_q;
  logic signed [SCALED_W-1:0]  mx_q, my_q;
  logic signed [CENTER_W-1:0]  cw_q, ch_q;
  logic                        behind_q, behind2_q;
  logic signed [NUM_W-1:0]     num_x_q, num_y_q;
  logic [DIVU_W-1:0]           div_q;
  logic signed [FOCAL_W:0]     focal_s;
  logic signed [SCR_W:0]       scr_w_s, scr_h_s;

  assign focal_s = signed'({1'b0, cfg_i.focal});
  assign scr_w_s = signed'({1'b0, cfg_i.scr_w});
  assign scr_h_s = signed'({1'b0, cfg_i.scr_h});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q     <= DEN_W'(rz_i) + signed'(DEN_W'({1'b0, cfg_i.depth}));
      rx_q      <= rx_i;
      ry_q      <= ry_i;
      mx_q      <= rx_q * focal_s;
      my_q      <= ry_q * focal_s;
      cw_q      <= scr_w_s * den_q;
      ch_q      <= scr_h_s * den_q;
      behind_q  <= den_q[DEN_W-1] || (den_q == '0);
      den2_q    <= den_q;
      num_x_q   <= NUM_W'(mx_q) + (NUM_W'(cw_q) <<< HALF_SHIFT);
      num_y_q   <= (NUM_W'(ch_q) <<< HALF_SHIFT) - NUM_W'(my_q);
      div_q     <= {den2_q[DEN_W-2:0], FOCAL_FRAC'(0)};
      behind2_q <= behind_q;
    end
  end

  assign valid_o  = valid_q[2];
  assign num_x_o  = num_x_q;
  assign num_y_o  = num_y_q;
  assign div_o    = div_q;
  assign behind_o = behind2_q;

endmodule
`default_nettype wire

// ===== src/vrpp_divide.sv =====
// two-lane pipelined restoring divider, one quotient bit per stage, with clamp to pixel range
`timescale 1ns / 1ps
`default_nettype none
module vrpp_divide
  import vrpp_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire logic signed [NUM_W-1:0] num_x_i,
  input  wire logic signed [NUM_W-1:0] num_y_i,
  input  wire logic [DIVU_W-1:0]       div_i,
  input  wire logic                    behind_i,
  output logic                         valid_o,
  output logic signed [PIX_W-1:0]      sx_o,
  output logic signed [PIX_W-1:0]      sy_o,
  output logic                         behind_o,
  output logic                         sat_o
);

  localparam logic [QUO_W-1:0] MAX_POS = QUO_W'((1 << (PIX_W - 1)) - 1);
  localparam logic [QUO_W-1:0] MAX_NEG = QUO_W'(1 << (PIX_W - 1));
  localparam logic [PIX_W-1:0] PIX_MAX = PIX_W'((1 << (PIX_W - 1)) - 1);
  localparam logic [PIX_W-1:0] PIX_MIN = PIX_W'(1 << (PIX_W - 1));

  // magnitude stage
  logic              a_valid_q, a_behind_q;
  logic [NUM_W-1:0]  a_mag_q [2];
  logic              a_neg_q [2];
  logic [DIVU_W-1:0] a_div_q;
  logic signed [NUM_W-1:0] num [2];

  // division steps, index 0 is the overflow check stage
  logic              s_valid_q  [QUO_W+1];
  logic              s_behind_q [QUO_W+1];
  logic [DIVU_W-1:0] s_div_q    [QUO_W+1];
  logic [CMP_W-1:0]  s_rem_q    [QUO_W+1][2];
  logic [QUO_W-1:0]  s_quo_q    [QUO_W+1][2];
  logic              s_neg_q    [QUO_W+1][2];
  logic              s_ovf_q    [QUO_W+1][2];

  // output stage
  logic              o_valid_q, o_behind_q, o_sat_q;
  logic [PIX_W-1:0]  o_pix_q [2];
  logic [PIX_W-1:0]  pix_d [2];
  logic              lsat [2];
  logic [QUO_W-1:0]  negq [2];

  assign num[0] = num_x_i;
  assign num[1] = num_y_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q    <= 1'b0;
      s_valid_q[0] <= 1'b0;
      o_valid_q    <= 1'b0;
    end else if (en_i) begin
      a_valid_q    <= valid_i;
      s_valid_q[0] <= a_valid_q;
      o_valid_q    <= s_valid_q[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_behind_q    <= behind_i;
      a_div_q       <= div_i;
      s_behind_q[0] <= a_behind_q;
      s_div_q[0]    <= a_div_q;
      for (int l = 0; l < 2; l++) begin
        a_neg_q[l]    <= num[l][NUM_W-1];
        a_mag_q[l]    <= num[l][NUM_W-1] ? NUM_W'(-num[l]) : NUM_W'(num[l]);
        s_neg_q[0][l] <= a_neg_q[l];
        s_ovf_q[0][l] <= CMP_W'(a_mag_q[l]) >= (CMP_W'(a_div_q) << QUO_W);
        s_rem_q[0][l] <= CMP_W'(a_mag_q[l]);
        s_quo_q[0][l] <= '0;
      end
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    localparam int BIT = QUO_W - 1 - k;
    logic [CMP_W-1:0] trial;
    logic [CMP_W-1:0] rem_d [2];
    logic [QUO_W-1:0] quo_d [2];

    assign trial = CMP_W'(s_div_q[k]) << BIT;

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        rem_d[l] = s_rem_q[k][l];
        quo_d[l] = s_quo_q[k][l];
        if (s_rem_q[k][l] >= trial) begin
          rem_d[l]      = s_rem_q[k][l] - trial;
          quo_d[l][BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s_valid_q[k+1] <= 1'b0;
      end else if (en_i) begin
        s_valid_q[k+1] <= s_valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_behind_q[k+1] <= s_behind_q[k];
        s_div_q[k+1]    <= s_div_q[k];
        for (int l = 0; l < 2; l++) begin
          s_rem_q[k+1][l] <= rem_d[l];
          s_quo_q[k+1][l] <= quo_d[l];
          s_neg_q[k+1][l] <= s_neg_q[k][l];
          s_ovf_q[k+1][l] <= s_ovf_q[k][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      negq[l] = -s_quo_q[QUO_W][l];
      lsat[l] = 1'b0;
      if (s_neg_q[QUO_W][l]) begin
        pix_d[l] = negq[l][PIX_W-1:0];
        if (s_ovf_q[QUO_W][l] || (s_quo_q[QUO_W][l] > MAX_NEG)) begin
          pix_d[l] = PIX_MIN;
          lsat[l]  = 1'b1;
        end
      end else begin
        pix_d[l] = s_quo_q[QUO_W][l][PIX_W-1:0];
        if (s_ovf_q[QUO_W][l] || (s_quo_q[QUO_W][l] > MAX_POS)) begin
          pix_d[l] = PIX_MAX;
          lsat[l]  = 1'b1;
        end
      end
      if (s_behind_q[QUO_W]) begin
        pix_d[l] = '0;
        lsat[l]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o_pix_q    <= pix_d;
      o_behind_q <= s_behind_q[QUO_W];
      o_sat_q    <= lsat[0] || lsat[1];
    end
  end

  assign valid_o  = o_valid_q;
  assign sx_o     = signed'(o_pix_q[0]);
  assign sy_o     = signed'(o_pix_q[1]);
  assign behind_o = o_behind_q;
  assign sat_o    = o_sat_q;

endmodule
`default_nettype wire

// ===== src/vertex_rotate_perspective_project_core.sv =====
// top level of the vertex rotate and perspective projection core
// Takes one signed q8.16 vertex per cycle unless stalled and returns its rotated,
// perspective-projected pixel position: two stages of matrix multiply, three of depth
// offset, focal and centering products, then a restoring divider that retires one
// quotient bit per stage (17 stages) between magnitude, overflow check and clamp stages.
// The whole pipeline advances together; in_ready_o drops only while a finished beat
// waits on a stalled output. Registers are written over the apb port at byte address
// 8*index and should be changed only while no vertex is in flight.
`timescale 1ns / 1ps
`default_nettype none
module vertex_rotate_perspective_project_core
  import vrpp_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [ADDR_W-1:0]         paddr,
  input  wire logic [DATA_W-1:0]         pwdata,
  output logic      [DATA_W-1:0]         prdata,
  output logic                           pready,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic signed [COORD_W-1:0] vertex_x_i,
  input  wire logic signed [COORD_W-1:0] vertex_y_i,
  input  wire logic signed [COORD_W-1:0] vertex_z_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic signed [PIX_W-1:0]        screen_x_o,
  output logic signed [PIX_W-1:0]        screen_y_o,
  output logic                           behind_camera_o,
  output logic                           saturated_o
);

  cfg_t                    cfg;
  logic                    en;
  logic                    rot_valid, prj_valid;
  logic signed [ROT_W-1:0] rx, ry, rz;
  logic signed [NUM_W-1:0] num_x, num_y;
  logic [DIVU_W-1:0]       div;
  logic                    behind;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  vrpp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  vrpp_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .vx_i    (vertex_x_i),
    .vy_i    (vertex_y_i),
    .vz_i    (vertex_z_i),
    .cfg_i   (cfg),
    .valid_o (rot_valid),
    .rx_o    (rx),
    .ry_o    (ry),
    .rz_o    (rz)
  );

  vrpp_project u_project (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (rot_valid),
    .rx_i     (rx),
    .ry_i     (ry),
    .rz_i     (rz),
    .cfg_i    (cfg),
    .valid_o  (prj_valid),
    .num_x_o  (num_x),
    .num_y_o  (num_y),
    .div_o    (div),
    .behind_o (behind)
  );

  vrpp_divide u_divide (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (prj_valid),
    .num_x_i  (num_x),
    .num_y_i  (num_y),
    .div_i    (div),
    .behind_i (behind),
    .valid_o  (out_valid_o),
    .sx_o     (screen_x_o),
    .sy_o     (screen_y_o),
    .behind_o (behind_camera_o),
    .sat_o    (saturated_o)
  );

endmodule
`default_nettype wire

// ===== verif/vertex_rotate_perspective_project_core_tb.sv =====
// self-checking testbench for the vertex rotate and perspective projection core
`timescale 1ns / 1ps
module vertex_rotate_perspective_project_core_tb;
  import vrpp_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PIPE_DRAIN  = 40;

  typedef struct {
    logic signed [PIX_W-1:0] sx;
    logic signed [PIX_W-1:0] sy;
    logic                    behind;
    logic                    sat;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready_o;
  logic signed [COORD_W-1:0] vx = '0, vy = '0, vz = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  logic signed [PIX_W-1:0] screen_x_o, screen_y_o;
  logic behind_camera_o, saturated_o;

  cfg_t   cfg;
  pixel_t expected_pixels[$];
  int     errors = 0;
  int     cycles = 0;
  int     vertices_sent = 0;
  int     pixels_seen = 0;
  int     behind_seen = 0;
  int     sat_seen = 0;
  int     reg_writes = 0;
  int     burst_left = 0;
  int     stall_pct = 0;
  int     hold_cycles = 0;
  bit     hold_req = 0;

  vertex_rotate_perspective_project_core dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i(in_valid), .in_ready_o,
    .vertex_x_i(vx), .vertex_y_i(vy), .vertex_z_i(vz),
    .out_valid_o, .out_ready_i(out_ready),
    .screen_x_o, .screen_y_o, .behind_camera_o, .saturated_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_req) begin
      hold_req = 0;
      hold_cycles <= 150;
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic longint coef_of(logic [ROW_W-1:0] row, int k);
    logic signed [COEF_W-1:0] c;
    c = row[k*COEF_W +: COEF_W];
    return longint'(c);
  endfunction

  function automatic longint rotate_row(logic [ROW_W-1:0] row, longint x, longint y,
                                        longint z);
    longint s;
    s = coef_of(row, 0) * x + coef_of(row, 1) * y + coef_of(row, 2) * z;
    s = s >>> FRAC_W;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s;
  endfunction

  function automatic longint clamp_pix(longint v, ref logic sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 32767;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return -32768;
    end
    return v;
  endfunction

  function automatic pixel_t project_vertex(logic signed [COORD_W-1:0] x,
                                            logic signed [COORD_W-1:0] y,
                                            logic signed [COORD_W-1:0] z);
    pixel_t p;
    longint rx, ry, rz, den, nx, ny;
    logic sat;
    rx = rotate_row(cfg.row_x, x, y, z);
    ry = rotate_row(cfg.row_y, x, y, z);
    rz = rotate_row(cfg.row_z, x, y, z);
    den = rz + longint'(cfg.depth);
    p.sx = '0;
    p.sy = '0;
    p.sat = 1'b0;
    p.behind = 1'b1;
    if (den > 0) begin
      sat = 1'b0;
      nx = rx * longint'(cfg.focal) + longint'(cfg.scr_w) * den * 128;
      ny = -ry * longint'(cfg.focal) + longint'(cfg.scr_h) * den * 128;
      p.sx = PIX_W'(clamp_pix(nx / (den * 256), sat));
      p.sy = PIX_W'(clamp_pix(ny / (den * 256), sat));
      p.sat = sat;
      p.behind = 1'b0;
    end
    return p;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
  endtask

  // result checker
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      pixels_seen++;
      if (expected_pixels.size() == 0) begin
        report_mismatch("beat with nothing pending", pixels_seen, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (screen_x_o !== want.sx) report_mismatch("screen_x", screen_x_o, want.sx);
        if (screen_y_o !== want.sy) report_mismatch("screen_y", screen_y_o, want.sy);
        if (behind_camera_o !== want.behind)
          report_mismatch("behind_camera", behind_camera_o, want.behind);
        if (saturated_o !== want.sat) report_mismatch("saturated", saturated_o, want.sat);
        behind_seen += want.behind;
        sat_seen += want.sat;
      end
    end
  end

  task automatic send_vertex(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                             logic signed [COORD_W-1:0] z);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    vx <= x;
    vy <= y;
    vz <= z;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_pixels.push_back(project_vertex(x, y, z));
    vertices_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 3'b000});
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ROW_X: cfg.row_x = value[ROW_W-1:0];
      REG_ROW_Y: cfg.row_y = value[ROW_W-1:0];
      REG_ROW_Z: cfg.row_z = value[ROW_W-1:0];
      REG_FOCAL: cfg.focal = value[FOCAL_W-1:0];
      REG_DEPTH: cfg.depth = value[DEPTH_W-1:0];
      REG_SCR_W: cfg.scr_w = value[SCR_W-1:0];
      REG_SCR_H: cfg.scr_h = value[SCR_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [COEF_W-1:0] small_coef();
    int c;
    c = $urandom_range(0, 131072) - 65536;
    return COEF_W'(c);
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    int c;
    if ($urandom_range(2) == 0) return COORD_W'($urandom);
    c = $urandom_range(0, 1048576) - 524288;
    return COORD_W'(c);
  endfunction

  task automatic load_config(logic [ROW_W-1:0] rx, logic [ROW_W-1:0] ry,
                             logic [ROW_W-1:0] rz, logic [FOCAL_W-1:0] f,
                             logic [DEPTH_W-1:0] d, logic [SCR_W-1:0] w,
                             logic [SCR_W-1:0] h);
    write_reg(REG_ROW_X, DATA_W'(rx));
    write_reg(REG_ROW_Y, DATA_W'(ry));
    write_reg(REG_ROW_Z, DATA_W'(rz));
    write_reg(REG_FOCAL, DATA_W'(f));
    write_reg(REG_DEPTH, DATA_W'(d));
    write_reg(REG_SCR_W, DATA_W'(w));
    write_reg(REG_SCR_H, DATA_W'(h));
  endtask

  task automatic test_reset_defaults;
    stall_pct = 0;
    send_vertex(0, 0, 0);
    send_vertex(24'sh010000, 24'sh010000, 24'sh010000);
    send_vertex(24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
    send_vertex(-24'sh800000, -24'sh800000, -24'sh800000);
    send_vertex(24'sh7fffff, -24'sh800000, 0);
    send_vertex(0, 0, -24'sh050000);
    send_vertex(0, 0, -24'sh060000);
    send_vertex(0, 0, -24'sh04ffff);
    send_vertex(24'sh7f0000, 0, 0);
    send_vertex(0, -24'sh7f0000, 0);
    send_vertex(-24'sh000001, 24'sh000001, 24'sh000001);
    send_vertex(24'sh020000, -24'sh018000, 24'sh008000);
    drain();
  endtask

  task automatic test_config_extremes;
    load_config({2{27'h4_0000_1}} , {18'h1ffff, 18'h20000, 18'h1ffff},
                {18'h20000, 18'h1ffff, 18'h20000}, 24'hffffff, 23'd0, 14'd0, 14'h3fff);
    stall_pct = 30;
    send_vertex(24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
    send_vertex(-24'sh800000, 24'sh7fffff, -24'sh800000);
    send_vertex(24'sh000100, -24'sh000100, -24'sh010000);
    send_vertex(0, 0, 0);
    drain();
    load_config({3{18'h0ffff}}, {18'h00000, 18'h10000, 18'h00000},
                {18'h10000, 18'h00000, 18'h00000}, 24'd0, 23'h7fffff, 14'd8192, 14'd1);
    send_vertex(24'sh123456, -24'sh654321, 24'sh7fffff);
    send_vertex(-24'sh800000, 24'sh000001, -24'sh800000);
    send_vertex(24'sh010000, 24'sh010000, 24'sh010000);
    drain();
  endtask

  task automatic test_random_phases;
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 0)
        load_config(ROW_X_RST, ROW_Y_RST, ROW_Z_RST, FOCAL_RST, DEPTH_RST, SCR_W_RST,
                    SCR_H_RST);
      else if (phase == 3)
        load_config(ROW_W'(rand64()), ROW_W'(rand64()), ROW_W'(rand64()),
                    FOCAL_W'($urandom), DEPTH_W'($urandom), SCR_W'($urandom),
                    SCR_W'($urandom));
      else
        load_config({small_coef(), small_coef(), small_coef()},
                    {small_coef(), small_coef(), small_coef()},
                    {small_coef(), small_coef(), small_coef()},
                    FOCAL_W'($urandom_range(1, 400000)),
                    DEPTH_W'($urandom_range(0, 1500000)),
                    SCR_W'($urandom_range(1, 8192)), SCR_W'($urandom_range(1, 8192)));
      stall_pct = (phase == 1) ? 0 : $urandom_range(10, 60);
      repeat (85) send_vertex(rand_coord(), rand_coord(), rand_coord());
      drain();
    end
  endtask

  task automatic test_output_backpressure;
    stall_pct = 20;
    hold_req = 1;
    repeat (60) send_vertex(rand_coord(), rand_coord(), rand_coord());
    drain();
  endtask

  initial begin
    cfg = '{ROW_X_RST, ROW_Y_RST, ROW_Z_RST, FOCAL_RST, DEPTH_RST, SCR_W_RST, SCR_H_RST};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_config_extremes();
    test_random_phases();
    test_output_backpressure();
    repeat (PIPE_DRAIN) @(posedge clk_i);
    $display("covered %0d vertices over %0d register writes", vertices_sent, reg_writes);
    $display("results: %0d checked, %0d behind camera, %0d clamped",
             pixels_seen, behind_seen, sat_seen);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_pixels.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
